// File: sv/nbs_pkg.sv
`default_nettype none

package nbs_pkg;

   localparam int MAX_JOBS_DEFAULT = 16;

   localparam int ARRIVAL_W  = 16;
   localparam int BURST_W    = 16;
   localparam int PRIORITY_W = 8;
   localparam int KEY_W      = 16;
   localparam int JOB_ID_W   = 5;
   localparam int WAIT_W     = 21;
   localparam int TOTAL_W    = 25;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_FIELDS_W = JOB_ID_W + ARRIVAL_W + BURST_W + PRIORITY_W
                                 + 2 * WAIT_W + 2 * TOTAL_W;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_FIELDS_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int POLICY_W   = 2;

   localparam logic CSR_IDX_POLICY = 1'b0;

   localparam logic [POLICY_W-1:0] POLICY_FCFS = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_SJF  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_PRIO = 2'd2;

   typedef struct packed {
      logic [PRIORITY_W-1:0] priority_level;
      logic [BURST_W-1:0]    burst_time;
      logic [ARRIVAL_W-1:0]  arrival_time;
   } job_type;

endpackage

`default_nettype wire

// File: sv/nbs_job_ram.sv
`default_nettype none

module nbs_job_ram #(
   parameter int MAX_JOBS = nbs_pkg::MAX_JOBS_DEFAULT
) (
   input  wire                              clock,
   input  wire                              wr_en,
   input  wire  [$clog2(MAX_JOBS)-1:0]      wr_addr,
   input  nbs_pkg::job_type                 wr_data,
   input  wire  [$clog2(MAX_JOBS)-1:0]      rd_addr,
   output nbs_pkg::job_type                 rd_data
);
   import nbs_pkg::*;

   job_type mem_ff [MAX_JOBS];
   job_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/nonpreemptive_batch_scheduler.sv
// Jobs are loaded one word per cycle (arrival, burst, priority) into a job
// memory of MAX_JOBS entries and numbered from 1 in load order; words beyond
// MAX_JOBS are dropped. The word with tlast set closes the batch and starts
// non-preemptive scheduling under the policy register (0 first come first
// served, 1 shortest job first, 2 lowest priority value first, 3 acts as 0).
// No new job is taken until the last result of the batch has been handed to
// the output register. Each pick reads every stored job once through the
// single read port of the job memory. The last result of a batch carries
// tlast and the batch totals; the totals read zero on all other results.
`default_nettype none

module nonpreemptive_batch_scheduler #(
   parameter int MAX_JOBS = nbs_pkg::MAX_JOBS_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,

   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // arrival_time[15:0], burst_time[31:16], priority_level[39:32]
   input  wire  [nbs_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  wire                                  req_tlast,

   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // job_id[4:0], job_arrival[20:5], job_burst[36:21], job_priority[44:37],
   // wait_ticks[65:45], turnaround_ticks[86:66], total_wait[111:87],
   // total_turnaround[136:112], zero padding above
   output logic [nbs_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tlast,

   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [nbs_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  wire  [nbs_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [nbs_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import nbs_pkg::*;

   localparam int IdxW   = $clog2(MAX_JOBS);
   localparam int CountW = $clog2(MAX_JOBS + 1);
   localparam int ClockW = ARRIVAL_W + $clog2(MAX_JOBS + 1);
   localparam int SumW   = (ClockW > TOTAL_W) ? ClockW : TOTAL_W;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_SETTLE,
      ST_CALC,
      ST_POST
   } state_type;

   state_type             state_ff;
   logic [POLICY_W-1:0]   policy_ff;

   logic [CountW-1:0]     count_ff;
   logic [CountW-1:0]     rd_cnt_ff;
   logic [CountW-1:0]     pick_cnt_ff;
   logic [MAX_JOBS-1:0]   done_ff;
   logic [ClockW-1:0]     clock_ff;
   logic [SumW-1:0]       wait_sum_ff;
   logic [SumW-1:0]       tat_sum_ff;

   logic                  chk_valid_ff;
   logic [IdxW-1:0]       chk_idx_ff;

   logic                  found_ff;
   job_type               best_job_ff;
   logic [IdxW-1:0]       best_idx_ff;
   logic [KEY_W-1:0]      best_key_ff;

   logic                  group_found_ff;
   job_type               group_job_ff;
   logic [IdxW-1:0]       group_idx_ff;
   logic [KEY_W-1:0]      group_key_ff;

   job_type               pick_job_ff;
   logic [IdxW-1:0]       pick_idx_ff;
   logic [SumW-1:0]       wait_ff;
   logic [SumW-1:0]       tat_ff;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   logic                  req_accept;
   logic                  store_en;
   job_type               req_job;
   job_type               rd_job;
   logic [IdxW-1:0]       rd_addr;
   logic                  issue;

   logic [KEY_W-1:0]      chk_key;
   logic                  chk_open;
   logic                  chk_arrived;
   logic                  take_best;
   logic                  take_group;

   logic                  out_free;
   logic                  last_pick;
   logic [SumW-1:0]       wait_sum_in;
   logic [SumW-1:0]       tat_sum_in;
   logic [SumW-1:0]       id_in;
   logic [TOTAL_W-1:0]    tot_wait_in;
   logic [TOTAL_W-1:0]    tot_tat_in;

   // Configuration port.
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_FCFS;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_POLICY)) begin
         policy_ff <= csr_pwdata[POLICY_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_POLICY) begin
         csr_prdata = CSR_DATA_W'(policy_ff);
      end
   end

   // Job memory.
   assign req_tready = (state_ff == ST_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign store_en   = req_accept && (count_ff < CountW'(MAX_JOBS));
   assign req_job    = job_type'(req_tdata);
   assign issue      = (state_ff == ST_SCAN) && (rd_cnt_ff < count_ff);
   assign rd_addr    = rd_cnt_ff[IdxW-1:0];

   nbs_job_ram #(
      .MAX_JOBS (MAX_JOBS)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[IdxW-1:0]),
      .wr_data (req_job),
      .rd_addr (rd_addr),
      .rd_data (rd_job)
   );

   // Candidate compare on the word read back from memory.
   always_comb begin
      unique case (policy_ff)
         POLICY_SJF:  chk_key = rd_job.burst_time;
         POLICY_PRIO: chk_key = KEY_W'(rd_job.priority_level);
         default:     chk_key = rd_job.arrival_time;
      endcase
   end

   assign chk_open    = chk_valid_ff && !done_ff[chk_idx_ff];
   assign chk_arrived = ClockW'(rd_job.arrival_time) <= clock_ff;

   assign take_best = chk_open && chk_arrived
                      && (!found_ff || (chk_key < best_key_ff)
                          || ((chk_key == best_key_ff)
                              && (rd_job.arrival_time < best_job_ff.arrival_time)));

   // Earliest unrun arrival, best key within that arrival group.
   assign take_group = chk_open
                       && (!group_found_ff
                           || (rd_job.arrival_time < group_job_ff.arrival_time)
                           || ((rd_job.arrival_time == group_job_ff.arrival_time)
                               && (chk_key < group_key_ff)));

   // Result assembly.
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign last_pick   = CountW'(pick_cnt_ff + 1'b1) == count_ff;
   assign wait_sum_in = wait_sum_ff + wait_ff;
   assign tat_sum_in  = tat_sum_ff + tat_ff;
   assign id_in       = SumW'(pick_idx_ff) + SumW'(1);
   assign tot_wait_in = last_pick ? wait_sum_in[TOTAL_W-1:0] : '0;
   assign tot_tat_in  = last_pick ? tat_sum_in[TOTAL_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         count_ff       <= '0;
         rd_cnt_ff      <= '0;
         pick_cnt_ff    <= '0;
         done_ff        <= '0;
         clock_ff       <= '0;
         wait_sum_ff    <= '0;
         tat_sum_ff     <= '0;
         chk_valid_ff   <= 1'b0;
         found_ff       <= 1'b0;
         group_found_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         chk_valid_ff <= issue;
         chk_idx_ff   <= rd_addr;

         if (rsp_tready && (state_ff != ST_POST)) begin
            rsp_valid_ff <= 1'b0;
         end

         if (take_best) begin
            found_ff    <= 1'b1;
            best_job_ff <= rd_job;
            best_idx_ff <= chk_idx_ff;
            best_key_ff <= chk_key;
         end
         if (take_group) begin
            group_found_ff <= 1'b1;
            group_job_ff   <= rd_job;
            group_idx_ff   <= chk_idx_ff;
            group_key_ff   <= chk_key;
         end

         unique case (state_ff)
            ST_LOAD: begin
               if (req_accept) begin
                  if (store_en) begin
                     count_ff <= CountW'(count_ff + 1'b1);
                  end
                  if (req_tlast) begin
                     rd_cnt_ff      <= '0;
                     pick_cnt_ff    <= '0;
                     found_ff       <= 1'b0;
                     group_found_ff <= 1'b0;
                     state_ff       <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (issue) begin
                  rd_cnt_ff <= CountW'(rd_cnt_ff + 1'b1);
               end else if (!chk_valid_ff) begin
                  state_ff <= ST_SETTLE;
               end
            end
            ST_SETTLE: begin
               if (found_ff) begin
                  pick_job_ff          <= best_job_ff;
                  pick_idx_ff          <= best_idx_ff;
                  done_ff[best_idx_ff] <= 1'b1;
               end else begin
                  pick_job_ff           <= group_job_ff;
                  pick_idx_ff           <= group_idx_ff;
                  done_ff[group_idx_ff] <= 1'b1;
                  clock_ff              <= ClockW'(group_job_ff.arrival_time);
               end
               state_ff <= ST_CALC;
            end
            ST_CALC: begin
               wait_ff  <= SumW'(clock_ff) - SumW'(pick_job_ff.arrival_time);
               tat_ff   <= SumW'(clock_ff) + SumW'(pick_job_ff.burst_time)
                           - SumW'(pick_job_ff.arrival_time);
               clock_ff <= clock_ff + ClockW'(pick_job_ff.burst_time);
               state_ff <= ST_POST;
            end
            ST_POST: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_last_ff  <= last_pick;
                  rsp_data_ff  <= {RSP_PAD_W'(0), tot_tat_in, tot_wait_in,
                                   tat_ff[WAIT_W-1:0], wait_ff[WAIT_W-1:0],
                                   pick_job_ff.priority_level,
                                   pick_job_ff.burst_time,
                                   pick_job_ff.arrival_time,
                                   id_in[JOB_ID_W-1:0]};
                  if (last_pick) begin
                     count_ff    <= '0;
                     done_ff     <= '0;
                     clock_ff    <= '0;
                     wait_sum_ff <= '0;
                     tat_sum_ff  <= '0;
                     state_ff    <= ST_LOAD;
                  end else begin
                     wait_sum_ff    <= wait_sum_in;
                     tat_sum_ff     <= tat_sum_in;
                     pick_cnt_ff    <= CountW'(pick_cnt_ff + 1'b1);
                     rd_cnt_ff      <= '0;
                     found_ff       <= 1'b0;
                     group_found_ff <= 1'b0;
                     state_ff       <= ST_SCAN;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
   import nbs_pkg::*;

   localparam int MAX_JOBS    = MAX_JOBS_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 2 * (MAX_JOBS + 5);

   localparam logic [POLICY_W-1:0]   POLICY_SPARE = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] POLICY_ADDR  = CSR_ADDR_W'(4 * CSR_IDX_POLICY);

   typedef enum int {SPREAD_TIGHT, SPREAD_FULL, SPREAD_GAPPY} spread_type;

   typedef struct packed {
      logic [RSP_PAD_W-1:0]  pad;
      logic [TOTAL_W-1:0]    total_turnaround;
      logic [TOTAL_W-1:0]    total_wait;
      logic [WAIT_W-1:0]     turnaround_ticks;
      logic [WAIT_W-1:0]     wait_ticks;
      logic [PRIORITY_W-1:0] job_priority;
      logic [BURST_W-1:0]    job_burst;
      logic [ARRIVAL_W-1:0]  job_arrival;
      logic [JOB_ID_W-1:0]   job_id;
   } job_report_type;

   typedef struct packed {
      logic           final_flag;
      job_report_type word;
   } report_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [POLICY_W-1:0]   active_policy = POLICY_FCFS;
   logic [ARRIVAL_W-1:0]  stored_arrival [MAX_JOBS];
   logic [BURST_W-1:0]    stored_burst [MAX_JOBS];
   logic [PRIORITY_W-1:0] stored_priority [MAX_JOBS];
   int                    stored_count = 0;
   report_entry_type      expected_reports [$];

   bit          tx_idle = 1'b1;
   bit          rx_idle = 1'b1;
   int          hold_requests = 0;
   int          holds_served = 0;
   int          rsp_hold_left = 0;
   int          rsp_stall_left = 0;
   int unsigned cycle_count = 0;
   int          mismatches = 0;
   int          jobs_sent = 0;
   int          jobs_dropped = 0;
   int          batches_closed = 0;
   int          reports_checked = 0;
   bit [3:0]    policies_seen = '0;

   nonpreemptive_batch_scheduler #(.MAX_JOBS(MAX_JOBS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timed out after %0d cycles, %0d words still expected",
               $time, cycle_count, expected_reports.size());
      $display("end of test: mismatches");
      $finish;
   end

   function automatic logic [15:0] sort_key(int idx);
      case (active_policy)
         POLICY_SJF: begin
            return stored_burst[idx];
         end
         POLICY_PRIO: begin
            return {8'd0, stored_priority[idx]};
         end
         default: begin
            return stored_arrival[idx];
         end
      endcase
   endfunction

   function automatic bit prefers(int a, int b);
      if (sort_key(a) != sort_key(b))
         return sort_key(a) < sort_key(b);
      return stored_arrival[a] < stored_arrival[b];
   endfunction

   function automatic void schedule_batch();
      bit               ran [MAX_JOBS];
      int unsigned      now;
      int unsigned      earliest;
      int unsigned      wait_t;
      int unsigned      tat_t;
      int unsigned      wait_total;
      int unsigned      tat_total;
      int               pick;
      bit               found;
      report_entry_type entry;
      for (int i = 0; i < MAX_JOBS; i++) ran[i] = 1'b0;
      wait_total = 0;
      tat_total = 0;
      now = 0;
      for (int k = 0; k < stored_count; k++) begin
         earliest = 32'hFFFF_FFFF;
         for (int i = 0; i < stored_count; i++)
            if (!ran[i] && stored_arrival[i] < earliest) earliest = stored_arrival[i];
         if (k == 0 || earliest > now) now = earliest;
         found = 1'b0;
         pick = 0;
         for (int i = 0; i < stored_count; i++) begin
            if (!ran[i] && stored_arrival[i] <= now) begin
               if (!found || prefers(i, pick)) begin
                  pick = i;
                  found = 1'b1;
               end
            end
         end
         ran[pick] = 1'b1;
         wait_t = now - stored_arrival[pick];
         now = now + stored_burst[pick];
         tat_t = wait_t + stored_burst[pick];
         wait_total = wait_total + wait_t;
         tat_total = tat_total + tat_t;
         entry = '0;
         entry.word.job_id = JOB_ID_W'(pick + 1);
         entry.word.job_arrival = stored_arrival[pick];
         entry.word.job_burst = stored_burst[pick];
         entry.word.job_priority = stored_priority[pick];
         entry.word.wait_ticks = WAIT_W'(wait_t);
         entry.word.turnaround_ticks = WAIT_W'(tat_t);
         if (k == stored_count - 1) begin
            entry.word.total_wait = TOTAL_W'(wait_total);
            entry.word.total_turnaround = TOTAL_W'(tat_total);
            entry.final_flag = 1'b1;
         end
         expected_reports.push_back(entry);
      end
   endfunction

   function automatic void load_job(job_type job, logic last);
      if (stored_count < MAX_JOBS) begin
         stored_arrival[stored_count] = job.arrival_time;
         stored_burst[stored_count] = job.burst_time;
         stored_priority[stored_count] = job.priority_level;
         stored_count++;
      end else begin
         jobs_dropped++;
      end
      if (last) begin
         schedule_batch();
         batches_closed++;
         policies_seen[active_policy] = 1'b1;
         stored_count = 0;
      end
   endfunction

   function automatic void check_field(string name, longint unsigned exp,
                                       longint unsigned act);
      if (exp != act) begin
         mismatches++;
         $display("%0t: %s expected %0d, got %0d", $time, name, exp, act);
      end
   endfunction

   function automatic void check_report(job_report_type got, logic got_last);
      report_entry_type exp;
      if (expected_reports.size() == 0) begin
         mismatches++;
         $display("%0t: word with no expectation, expected none, got job %0d",
                  $time, got.job_id);
         return;
      end
      exp = expected_reports.pop_front();
      reports_checked++;
      check_field("job_id", exp.word.job_id, got.job_id);
      check_field("job_arrival", exp.word.job_arrival, got.job_arrival);
      check_field("job_burst", exp.word.job_burst, got.job_burst);
      check_field("job_priority", exp.word.job_priority, got.job_priority);
      check_field("wait_ticks", exp.word.wait_ticks, got.wait_ticks);
      check_field("turnaround_ticks", exp.word.turnaround_ticks, got.turnaround_ticks);
      check_field("total_wait", exp.word.total_wait, got.total_wait);
      check_field("total_turnaround", exp.word.total_turnaround, got.total_turnaround);
      check_field("final_result", exp.final_flag, got_last);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_report(job_report_type'(rsp_tdata), rsp_tlast);
         rsp_stall_left = rx_idle ? $urandom_range(0, 11) : 0;
      end
      if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         rsp_hold_left = HOLD_CYCLES;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic job_type make_job(int arrival, int burst, int prio);
      job_type job;
      job.arrival_time = ARRIVAL_W'(arrival);
      job.burst_time = BURST_W'(burst);
      job.priority_level = PRIORITY_W'(prio);
      return job;
   endfunction

   function automatic job_type random_job(spread_type spread);
      case (spread)
         SPREAD_TIGHT: begin
            return make_job($urandom_range(0, 31), $urandom_range(0, 15),
                            $urandom_range(0, 3));
         end
         SPREAD_GAPPY: begin
            return make_job($urandom_range(0, 65535), $urandom_range(0, 200),
                            $urandom_range(0, 255));
         end
         default: begin
            return make_job($urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 255));
         end
      endcase
   endfunction

   task automatic send_job(job_type job, logic last);
      int gap;
      gap = tx_idle ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= job;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      jobs_sent++;
      load_job(job, last);
   endtask

   task automatic send_random_batch(int size);
      spread_type spread;
      case ($urandom_range(0, 3))
         0: spread = SPREAD_FULL;
         1: spread = SPREAD_GAPPY;
         default: spread = SPREAD_TIGHT;
      endcase
      for (int k = 0; k < size; k++) send_job(random_job(spread), k == size - 1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic program_policy(logic [POLICY_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = {(CSR_DATA_W - POLICY_W)'($urandom_range(0, 32'h3FFF_FFFF)), value};
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= POLICY_ADDR;
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      active_policy = value;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("policy readback", value, csr_prdata[POLICY_W-1:0]);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_extremes();
      program_policy(POLICY_FCFS);
      send_job(make_job(65535, 65535, 255), 1'b1);
      send_job(make_job(0, 0, 0), 1'b1);
      wait_drained();
   endtask

   // The early pair and the late pair each tie on burst and arrival, and the late pair forces an idle jump.
   task automatic test_ties_and_gaps();
      program_policy(POLICY_SJF);
      send_job(make_job(100, 5, 3), 1'b0);
      send_job(make_job(0, 10, 1), 1'b0);
      send_job(make_job(0, 10, 0), 1'b0);
      send_job(make_job(500, 0, 2), 1'b0);
      send_job(make_job(500, 0, 2), 1'b1);
      wait_drained();
   endtask

   // The closing word arrives when the batch is already full.
   task automatic test_batch_overflow();
      program_policy(POLICY_PRIO);
      for (int k = 0; k <= MAX_JOBS; k++)
         send_job(random_job(SPREAD_TIGHT), k == MAX_JOBS);
      wait_drained();
   endtask

   task automatic run_policy_phase(logic [POLICY_W-1:0] value, int budget,
                                   bit tx_on, bit rx_on);
      int start;
      int size;
      program_policy(value);
      tx_idle = tx_on;
      rx_idle = rx_on;
      start = jobs_sent;
      while (jobs_sent - start < budget) begin
         case ($urandom_range(0, 9))
            0: size = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
            1, 2, 3: size = $urandom_range(7, MAX_JOBS);
            default: size = $urandom_range(1, 6);
         endcase
         send_random_batch(size);
         if ($urandom_range(0, 3) == 0) wait_drained();
      end
      wait_drained();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
   endtask

   task automatic test_policy_sweep();
      run_policy_phase(POLICY_FCFS, 75, 1'b1, 1'b1);
      run_policy_phase(POLICY_SJF, 75, 1'b1, 1'b1);
      run_policy_phase(POLICY_PRIO, 75, 1'b1, 1'b1);
      run_policy_phase(POLICY_SPARE, 55, 1'b1, 1'b1);
      run_policy_phase(POLICY_SJF, 55, 1'b0, 1'b0);
      run_policy_phase(POLICY_PRIO, 55, 1'b1, 1'b0);
   endtask

   // The receiver holds off while two batches are offered back to back.
   task automatic test_backpressure();
      program_policy(POLICY_FCFS);
      tx_idle = 1'b0;
      hold_requests++;
      send_random_batch(6);
      send_random_batch(6);
      tx_idle = 1'b1;
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_ties_and_gaps();
      test_batch_overflow();
      test_policy_sweep();
      test_backpressure();
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("Ran %0d batches from %0d jobs (%0d beyond capacity), policy codes seen %b.",
               batches_closed, jobs_sent, jobs_dropped, policies_seen);
      $display("Checked %0d result words in %0d cycles, %0d mismatches.",
               reports_checked, cycle_count, mismatches);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
